>>> rtl/rud_pkg.sv
package rud_pkg;

    // datapath width of the recurrence (4..64)
    localparam int WIDTH = 32;
    // width of each operand and result field on the ports
    localparam int FIELD_W = 32;

    localparam int IN_TDATA_W  = ((2 * FIELD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * FIELD_W + 7) / 8) * 8;

    // one pipeline stage per quotient bit
    localparam int NUM_STAGES = WIDTH;

    typedef logic [WIDTH-1:0]   word_t;
    typedef logic [FIELD_W-1:0] field_t;

    typedef struct packed {
        word_t rem;      // partial remainder
        word_t quo;      // dividend bits shifting out, quotient bits shifting in
        word_t dvsr;
        logic  dbz;
    } stage_t;

endpackage

>>> rtl/restoring_unsigned_divider.sv
// Channel   Direction  tdata (low bit up)                  tuser
// s_axis    in         dividend[31:0], divisor[63:32]      -
// m_axis    out        quotient[31:0], remainder[63:32]    divide_by_zero
//
// One request accepted per cycle unless every stage is full behind a stalled result;
// WIDTH (32) register stages, each one quotient bit from a single trial subtract. A
// result passes through the stage registers in order before it shows on m_tvalid.
// Reset clears only the stage valid bits.
// Each stage holds while the next is full and stalled; empty stages keep filling,
// so a stalled result blocks new requests only once every stage is full.
module restoring_unsigned_divider
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rud_pkg::IN_TDATA_W-1:0]  s_tdata,   // dividend, divisor
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rud_pkg::OUT_TDATA_W-1:0] m_tdata,   // quotient, remainder
    output logic                            m_tuser    // divide_by_zero
);

    localparam int N  = rud_pkg::NUM_STAGES;
    localparam int FW = rud_pkg::FIELD_W;

    rud_pkg::stage_t stage_data  [0:N];
    logic            stage_valid [0:N];
    logic            stage_ready [0:N];
    rud_pkg::word_t  dividend_w;
    rud_pkg::word_t  divisor_w;
    rud_pkg::field_t quotient;
    rud_pkg::field_t remainder;

    assign dividend_w = rud_pkg::word_t'(s_tdata[FW-1:0]);
    assign divisor_w  = rud_pkg::word_t'(s_tdata[2*FW-1:FW]);

    assign stage_data[0] = '{rem: '0, quo: dividend_w, dvsr: divisor_w,
                             dbz: (divisor_w == '0)};

    assign stage_valid[0] = s_tvalid;
    assign s_tready       = stage_ready[0];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        rud_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    assign stage_ready[N] = m_tready;
    assign m_tvalid       = stage_valid[N];

    assign quotient  = rud_pkg::field_t'(stage_data[N].quo);
    assign remainder = rud_pkg::field_t'(stage_data[N].rem);
    assign m_tdata   = rud_pkg::OUT_TDATA_W'({remainder, quotient});
    assign m_tuser   = stage_data[N].dbz;

endmodule

>>> rtl/rud_stage.sv
module rud_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rud_pkg::stage_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output rud_pkg::stage_t out_data
);

    localparam int W = rud_pkg::WIDTH;

    logic            valid_reg;
    rud_pkg::stage_t data_reg;
    rud_pkg::stage_t data_next;
    logic [W-1:0]    shifted;
    logic [W:0]      trial;

    // slot takes a request when empty or when its content moves on
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        shifted   = {in_data.rem[W-2:0], in_data.quo[W-1]};
        // bit W of the shifted remainder comes back as the trial's top bit
        trial     = {in_data.rem[W-1], shifted} - {1'b0, in_data.dvsr};
        data_next = in_data;
        if (!in_data.dbz)
        begin
            if (!trial[W])
            begin
                data_next.rem = trial[W-1:0];
                data_next.quo = {in_data.quo[W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem = shifted;
                data_next.quo = {in_data.quo[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/rud_checker.sv
module rud_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rud_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    localparam int FW = rud_pkg::FIELD_W;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // divide by zero returns a zero remainder
    a_dbz_rem: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[2*FW-1:FW] == '0)
        else $error("divide by zero with nonzero remainder");

    // a draining output frees the whole pipe
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // nothing leaves right after reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

endmodule

bind restoring_unsigned_divider rud_checker u_rud_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb.sv
module tb;

    localparam int IDLE_LIMIT    = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 240;

    typedef struct packed {
        rud_pkg::field_t quo;
        rud_pkg::field_t rem;
        logic            dbz;
    } div_result_t;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rud_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rud_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;

    div_result_t pending_results[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches    = 0;
    int          div_checked   = 0;
    int          dbz_seen      = 0;
    int          idle_cycles   = 0;

    restoring_unsigned_divider dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // dividend, divisor
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // quotient, remainder
        .m_tuser  (m_tuser)    // divide_by_zero
    );

    always #10 clk = ~clk;

    // one quotient bit per step; carry is bit WIDTH of the shifted remainder
    function automatic div_result_t restoring_divide(input rud_pkg::field_t dvd,
                                                     input rud_pkg::field_t dvs);
        rud_pkg::word_t q;
        rud_pkg::word_t m;
        rud_pkg::word_t a;
        logic           carry;
        div_result_t    res;
        q = rud_pkg::word_t'(dvd);
        m = rud_pkg::word_t'(dvs);
        a = '0;
        if (m == '0)
        begin
            res.quo = rud_pkg::field_t'(q);
            res.rem = '0;
            res.dbz = 1'b1;
            return res;
        end
        for (int i = 0; i < rud_pkg::WIDTH; i++)
        begin
            carry = a[rud_pkg::WIDTH-1];
            a     = {a[rud_pkg::WIDTH-2:0], q[rud_pkg::WIDTH-1]};
            q     = q << 1;
            if (carry || a >= m)
            begin
                a    = a - m;
                q[0] = 1'b1;
            end
        end
        res.quo = rud_pkg::field_t'(q);
        res.rem = rud_pkg::field_t'(a);
        res.dbz = 1'b0;
        return res;
    endfunction

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles with no transfer", IDLE_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        div_result_t exp_res;
        div_result_t got_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res.quo = m_tdata[rud_pkg::FIELD_W-1:0];
            got_res.rem = m_tdata[2*rud_pkg::FIELD_W-1:rud_pkg::FIELD_W];
            got_res.dbz = m_tuser;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: unexpected result q=%h r=%h dbz=%b",
                             got_res.quo, got_res.rem, got_res.dbz);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                div_checked++;
                if (exp_res.dbz)
                    dbz_seen++;
                if (got_res !== exp_res)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("tb: mismatch exp q=%h r=%h dbz=%b got q=%h r=%h dbz=%b",
                                 exp_res.quo, exp_res.rem, exp_res.dbz,
                                 got_res.quo, got_res.rem, got_res.dbz);
                end
            end
        end
    end

    // holds tvalid high on exit so back-to-back requests follow without a gap
    task automatic send_division(input rud_pkg::field_t dvd, input rud_pkg::field_t dvs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dvs, dvd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(restoring_divide(dvd, dvs));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic void pick_operands(output rud_pkg::field_t dvd,
                                          output rud_pkg::field_t dvs);
        dvd = $urandom;
        case ($urandom_range(9))
            0:       dvs = '0;
            1, 2:    dvs = rud_pkg::field_t'($urandom_range(1, 255));
            3:
            begin
                dvs = $urandom;
                dvd = dvs >> $urandom_range(1, rud_pkg::FIELD_W - 1);
            end
            4:       dvs = dvd - rud_pkg::field_t'($urandom_range(0, 3));
            5:       dvs = rud_pkg::field_t'(1) << $urandom_range(0, rud_pkg::FIELD_W - 1);
            6:
            begin
                dvd = $urandom_range(1) ? '1 : '0;
                dvs = $urandom;
            end
            default: dvs = rud_pkg::field_t'($urandom) >> $urandom_range(0, rud_pkg::FIELD_W - 1);
        endcase
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_division('0, '0);
        send_division('1, '0);
        send_division(32'h0000_0001, '0);
        send_division(32'h8000_0000, '0);
        send_division('1, 32'h0000_0001);
        send_division('1, '1);
        send_division('0, '1);
        send_division('0, 32'h0000_0001);
        send_division(32'h0000_0007, 32'h0000_0009);
        send_division(32'h1234_5678, 32'h1234_5678);
        send_division(32'h1234_5678, 32'h1234_5679);
        send_division('1, 32'h8000_0000);
        send_division(32'h7FFF_FFFF, 32'h8000_0000);
        send_division('1, 32'h8000_0001);
        send_division('1, 32'h0000_0002);
        send_division(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_division(32'hAAAA_AAAA, 32'h5555_5555);
        send_division(32'h5555_5555, 32'h0000_0003);
        send_division(32'hDEAD_BEEF, 32'h0001_0000);
        send_division(32'h0000_FFFF, 32'hFFFF_0000);
        send_division(32'h0000_0064, 32'h0000_0007);
        send_division(32'hFFFF_0000, 32'h0000_FFFF);
        wait_drained();
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int count);
        rud_pkg::field_t dvd;
        rud_pkg::field_t dvs;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            pick_operands(dvd, dvs);
            send_division(dvd, dvs);
        end
    endtask

    // sender goes quiet until the pipe empties, then restarts
    task automatic test_pause_until_drained();
        rud_pkg::field_t dvd;
        rud_pkg::field_t dvs;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        for (int burst = 0; burst < 4; burst++)
        begin
            for (int i = 0; i < 12; i++)
            begin
                pick_operands(dvd, dvs);
                send_division(dvd, dvs);
            end
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(0, 0, RANDOM_ITEMS);
        test_random(58, 0, RANDOM_ITEMS);
        test_random(0, 58, RANDOM_ITEMS);
        test_random(20, 20, RANDOM_ITEMS);
        test_pause_until_drained();

        wait_drained();
        repeat (rud_pkg::NUM_STAGES + 16) @(posedge clk);

        $display("tb: %0d divisions checked, %0d by zero, %0d mismatches",
                 div_checked, dbz_seen, mismatches);
        $display("tb: directed corners, random operands under four idle/stall mixes, drain pauses");
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: %0d results never arrived", pending_results.size());
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rud_pkg.sv
rtl/rud_stage.sv
rtl/restoring_unsigned_divider.sv
rtl/rud_checker.sv
tb/tb.sv
